[rtl/gsdh_pkg.sv]
// Shared types and constants for the gamepad stick dead zone and hold block.
package gsdh_pkg;

   localparam int SLOTS       = 4;
   localparam int BUTTONS     = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int CNT_DEPTH   = SLOTS * BUTTONS;
   localparam int CNT_ADDR_W  = $clog2(CNT_DEPTH);

   localparam int DIV_N = 39;
   localparam int DIV_D = 24;
   localparam int DIV_Q = 16;

   localparam logic [14:0] FULL_TILT  = 15'd32767;
   localparam logic [23:0] FULL_TILT8 = 24'd8388352;
   localparam logic [14:0] DZ_RESET   = 15'd7864;
   localparam logic [7:0]  TRIG_RESET = 8'd30;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [2:0] CSR_DZ0  = 3'd0;
   localparam logic [2:0] CSR_DZ1  = 3'd1;
   localparam logic [2:0] CSR_DZ2  = 3'd2;
   localparam logic [2:0] CSR_DZ3  = 3'd3;
   localparam logic [2:0] CSR_TRIG = 3'd4;

   localparam logic [3:0] LAST_BUTTON = 4'(BUTTONS - 1);

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [15:0]        mag;
   } stick_res_type;

endpackage

[rtl/gsdh_ram.sv]
// Generic single write port RAM with registered read.
module gsdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/gsdh_div.sv]
// Restoring divider, one quotient bit per cycle, quotient known to fit 16 bits.
module gsdh_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gsdh_pkg::DIV_N-1:0]  dividend,
   input  logic [gsdh_pkg::DIV_D-1:0]  divisor,
   output logic [gsdh_pkg::DIV_Q-1:0]  quotient,
   output logic                        done
);
   import gsdh_pkg::*;

   logic [DIV_N-1:0] rem_ff, rem_in;
   logic [DIV_N-1:0] dsh_ff, dsh_in;
   logic [DIV_Q-1:0] q_ff, q_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ge;

   always_comb begin
      ge      = rem_ff >= dsh_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = {divisor, {(DIV_N - DIV_D){1'b0}}};
         q_in    = '0;
         cnt_in  = 4'(DIV_Q - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[DIV_Q-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;
endmodule

[rtl/gsdh_stick.sv]
// Stick lane: length by bitwise square root, then direction and magnitude divides.
module gsdh_stick (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [15:0]      x,
   input  logic signed [15:0]      y,
   input  logic [14:0]             dz,
   output gsdh_pkg::stick_res_type res,
   output logic                    res_ready
);
   import gsdh_pkg::*;

   typedef enum logic [2:0] {L_IDLE, L_SQ, L_SUM, L_ROOT, L_DIVGO, L_DIVW} lstate_type;

   lstate_type    state_ff;
   logic [15:0]   x_ff, y_ff;
   logic [14:0]   dz_ff;
   logic [31:0]   xsq_ff, ysq_ff;
   logic [29:0]   dd_ff;
   logic          zero_ff;
   logic [47:0]   v_ff, r_ff, bit_ff;
   stick_res_type res_ff;
   logic          rdy_ff;

   logic [15:0]      ax, ay;
   logic [31:0]      s;
   logic [47:0]      t;
   logic [23:0]      l8, lc8;
   logic [DIV_N-1:0] dvd_x, dvd_y, dvd_m;
   logic [DIV_D-1:0] den;
   logic [DIV_Q-1:0] qx, qy, qm;
   logic             dn_x, dn_y, dn_m, div_go;
   logic [15:0]      dir_x, dir_y;

   always_comb begin
      ax     = x_ff[15] ? (~x_ff + 16'd1) : x_ff;
      ay     = y_ff[15] ? (~y_ff + 16'd1) : y_ff;
      s      = xsq_ff + ysq_ff;
      t      = r_ff + bit_ff;
      l8     = r_ff[23:0];
      lc8    = (l8 > FULL_TILT8) ? FULL_TILT8 : l8;
      dvd_x  = {ax, 23'b0};
      dvd_y  = {ay, 23'b0};
      dvd_m  = {lc8 - {1'b0, dz_ff, 8'b0}, 15'b0};
      den    = {1'b0, FULL_TILT - dz_ff, 8'b0};
      div_go = state_ff == L_DIVGO;
      dir_x  = x_ff[15] ? (~qx + 16'd1) : (qx[15] ? 16'h7FFF : qx);
      dir_y  = y_ff[15] ? (~qy + 16'd1) : (qy[15] ? 16'h7FFF : qy);
   end

   gsdh_div u_div_x (.clock, .reset, .start(div_go), .dividend(dvd_x), .divisor(l8),
                     .quotient(qx), .done(dn_x));
   gsdh_div u_div_y (.clock, .reset, .start(div_go), .dividend(dvd_y), .divisor(l8),
                     .quotient(qy), .done(dn_y));
   gsdh_div u_div_m (.clock, .reset, .start(div_go), .dividend(dvd_m), .divisor(den),
                     .quotient(qm), .done(dn_m));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         rdy_ff   <= 1'b0;
      end else begin
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  x_ff     <= x;
                  y_ff     <= y;
                  dz_ff    <= dz;
                  rdy_ff   <= 1'b0;
                  state_ff <= L_SQ;
               end
            end
            L_SQ: begin
               xsq_ff   <= 32'(ax) * 32'(ax);
               ysq_ff   <= 32'(ay) * 32'(ay);
               dd_ff    <= 30'(dz_ff) * 30'(dz_ff);
               state_ff <= L_SUM;
            end
            L_SUM: begin
               zero_ff  <= (s == 32'd0) || (s < {2'b0, dd_ff});
               v_ff     <= {s, 16'b0};
               r_ff     <= '0;
               bit_ff   <= 48'd1 << 46;
               state_ff <= L_ROOT;
            end
            L_ROOT: begin
               if (v_ff >= t) begin
                  v_ff <= v_ff - t;
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff == 48'd1) begin
                  state_ff <= L_DIVGO;
               end
            end
            L_DIVGO: begin
               state_ff <= L_DIVW;
            end
            L_DIVW: begin
               if (dn_x && dn_y && dn_m) begin
                  if (zero_ff) begin
                     res_ff <= '0;
                  end else begin
                     res_ff.dir_x <= dir_x;
                     res_ff.dir_y <= dir_y;
                     res_ff.mag   <= (dz_ff == FULL_TILT) ? 16'h8000 : qm;
                  end
                  rdy_ff   <= 1'b1;
                  state_ff <= L_IDLE;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign res       = res_ff;
   assign res_ready = rdy_ff;
endmodule

[rtl/gamepad_stick_deadzone_and_hold.sv]
// Top level: two stick lanes, button merge with per-slot hold counters.
//
//   channel  | handshake             | payload
//   req      | req_valid/req_ready   | slot, sticks, button word, triggers
//   rsp      | rsp_valid/rsp_ready   | one button result with both stick results
//   csr      | csr_valid/csr_ready   | csr_index, csr_wdata
//
// One poll: accept, then the lanes (24-step square root, 16-step divides), then
// for each button result the counter RAM read-modify-write through T_RD, T_CALC
// and T_OUT, plus output stalls.
// A stalled rsp holds the engine; req_ready is high only when idle.
// Reset is synchronous; counter RAM needs no clearing (read only after a write).
module gamepad_stick_deadzone_and_hold (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_slot,
   input  logic signed [15:0] req_left_x,
   input  logic signed [15:0] req_left_y,
   input  logic signed [15:0] req_right_x,
   input  logic signed [15:0] req_right_y,
   input  logic [15:0]        req_button_word,
   input  logic [7:0]         req_left_trigger,
   input  logic [7:0]         req_right_trigger,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_slot_echo,
   output logic [3:0]         rsp_button_index,
   output logic               rsp_button_down,
   output logic [31:0]        rsp_hold_count,
   output logic               rsp_last_of_run,
   output logic signed [15:0] rsp_left_dir_x,
   output logic signed [15:0] rsp_left_dir_y,
   output logic [15:0]        rsp_left_magnitude,
   output logic signed [15:0] rsp_right_dir_x,
   output logic signed [15:0] rsp_right_dir_y,
   output logic [15:0]        rsp_right_magnitude,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import gsdh_pkg::*;

   typedef enum logic [2:0] {T_IDLE, T_LANE, T_RD, T_CALC, T_OUT} tstate_type;

   tstate_type       state_ff;
   logic [1:0]       slot_ff;
   logic [15:0]      now_ff;
   logic [15:0]      prev_ff [SLOTS];
   logic [3:0]       b_ff;
   logic [14:0]      dz_ff [SLOTS];
   logic [7:0]       thr_ff;
   logic             down_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;

   logic             accept, lane_go, l_rdy, r_rdy;
   stick_res_type    l_res, r_res;
   logic [15:0]      now_in;
   logic [CNT_ADDR_W-1:0] addr;
   logic [COUNT_WIDTH-1:0] rd_cnt, cnt_in;
   logic             down, was, wr_en;

   always_comb begin
      accept  = req_valid && req_ready;
      lane_go = accept && (32'(req_slot) < SLOTS);
      now_in  = {req_right_trigger > thr_ff, req_left_trigger > thr_ff,
                 req_button_word[15:12], req_button_word[9:0]};
      addr    = CNT_ADDR_W'({slot_ff, b_ff});
      down    = now_ff[b_ff];
      was     = prev_ff[slot_ff][b_ff];
      if (!down) begin
         cnt_in = '0;
      end else if (!was) begin
         cnt_in = COUNT_WIDTH'(1);
      end else if (rd_cnt != CNT_MAX) begin
         cnt_in = rd_cnt + COUNT_WIDTH'(1);
      end else begin
         cnt_in = rd_cnt;
      end
      wr_en = state_ff == T_CALC;
   end

   gsdh_stick u_left (.clock, .reset, .start(lane_go), .x(req_left_x), .y(req_left_y),
                      .dz(dz_ff[req_slot]), .res(l_res), .res_ready(l_rdy));
   gsdh_stick u_right (.clock, .reset, .start(lane_go), .x(req_right_x), .y(req_right_y),
                       .dz(dz_ff[req_slot]), .res(r_res), .res_ready(r_rdy));

   gsdh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CNT_DEPTH)) u_cnt_ram (
      .clock, .wr_en, .wr_addr(addr), .wr_data(cnt_in), .rd_addr(addr), .rd_data(rd_cnt));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         thr_ff   <= TRIG_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            dz_ff[i]   <= DZ_RESET;
            prev_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DZ0, CSR_DZ1, CSR_DZ2, CSR_DZ3: dz_ff[csr_index[1:0]] <= csr_wdata[14:0];
               CSR_TRIG: thr_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         case (state_ff)
            T_IDLE: begin
               if (lane_go) begin
                  slot_ff  <= req_slot;
                  now_ff   <= now_in;
                  b_ff     <= '0;
                  state_ff <= T_LANE;
               end
            end
            T_LANE: begin
               if (l_rdy && r_rdy) begin
                  state_ff <= T_RD;
               end
            end
            T_RD: begin
               state_ff <= T_CALC;
            end
            T_CALC: begin
               down_ff  <= down;
               cnt_ff   <= cnt_in;
               state_ff <= T_OUT;
            end
            T_OUT: begin
               if (rsp_ready) begin
                  if (b_ff == LAST_BUTTON) begin
                     prev_ff[slot_ff] <= now_ff;
                     state_ff         <= T_IDLE;
                  end else begin
                     b_ff     <= b_ff + 4'd1;
                     state_ff <= T_RD;
                  end
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign req_ready           = state_ff == T_IDLE;
   assign csr_ready           = 1'b1;
   assign rsp_valid           = state_ff == T_OUT;
   assign rsp_slot_echo       = slot_ff;
   assign rsp_button_index    = b_ff;
   assign rsp_button_down     = down_ff;
   assign rsp_hold_count      = 32'(cnt_ff);
   assign rsp_last_of_run     = b_ff == LAST_BUTTON;
   assign rsp_left_dir_x      = l_res.dir_x;
   assign rsp_left_dir_y      = l_res.dir_y;
   assign rsp_left_magnitude  = l_res.mag;
   assign rsp_right_dir_x     = r_res.dir_x;
   assign rsp_right_dir_y     = r_res.dir_y;
   assign rsp_right_magnitude = r_res.mag;
endmodule

[rtl/gsdh_checker.sv]
// Port-level checks for the top level, bound to it.
module gsdh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_button_index,
   input logic        rsp_button_down,
   input logic [31:0] rsp_hold_count,
   input logic        rsp_last_of_run
);
   import gsdh_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_button_index))
      else $error("rsp dropped or changed while stalled");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("new transaction taken while results pending");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> !req_ready)
      else $error("engine idle before last result");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_of_run == (rsp_button_index == LAST_BUTTON))
      else $error("last_of_run mismatch");

   a_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_button_down |-> rsp_hold_count == 32'd0)
      else $error("released button with nonzero count");
endmodule

bind gamepad_stick_deadzone_and_hold gsdh_checker u_gsdh_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_button_index,
   .rsp_button_down, .rsp_hold_count, .rsp_last_of_run);

[tb/sv/tb.sv]
// Testbench for the gamepad stick dead zone and hold block: random polls, self-checking.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gsdh_pkg::*;

   typedef struct packed {
      logic [1:0]         slot;
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic [15:0]        word;
      logic [7:0]         lt;
      logic [7:0]         rt;
   } poll_type;

   typedef struct packed {
      logic [1:0]         slot;
      logic [3:0]         idx;
      logic               down;
      logic [31:0]        cnt;
      logic               last;
      logic signed [15:0] ldx;
      logic signed [15:0] ldy;
      logic [15:0]        lm;
      logic signed [15:0] rdx;
      logic signed [15:0] rdy;
      logic [15:0]        rm;
   } button_res_type;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   logic req_valid = 0, req_ready;
   poll_type req_item = '0;
   logic rsp_valid, rsp_ready = 0;
   logic [1:0] rsp_slot_echo;
   logic [3:0] rsp_button_index;
   logic rsp_button_down, rsp_last_of_run;
   logic [31:0] rsp_hold_count;
   logic signed [15:0] rsp_left_dir_x, rsp_left_dir_y, rsp_right_dir_x, rsp_right_dir_y;
   logic [15:0] rsp_left_magnitude, rsp_right_magnitude;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   gamepad_stick_deadzone_and_hold dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_slot(req_item.slot), .req_left_x(req_item.lx), .req_left_y(req_item.ly),
      .req_right_x(req_item.rx), .req_right_y(req_item.ry),
      .req_button_word(req_item.word), .req_left_trigger(req_item.lt),
      .req_right_trigger(req_item.rt),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_slot_echo(rsp_slot_echo), .rsp_button_index(rsp_button_index),
      .rsp_button_down(rsp_button_down), .rsp_hold_count(rsp_hold_count),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_left_dir_x(rsp_left_dir_x), .rsp_left_dir_y(rsp_left_dir_y),
      .rsp_left_magnitude(rsp_left_magnitude),
      .rsp_right_dir_x(rsp_right_dir_x), .rsp_right_dir_y(rsp_right_dir_y),
      .rsp_right_magnitude(rsp_right_magnitude),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [14:0] dz_model [SLOTS];
   logic [7:0]  trig_model;
   logic [15:0] prev_mask [SLOTS];
   logic [31:0] hold_model [CNT_DEPTH];

   poll_type       pending_polls[$];
   button_res_type expected_buttons[$];
   int errors = 0;
   int stall_cycles = 0;
   int req_gap = 0;
   bit cfg_busy = 0;
   bit cfg_done = 0;
   logic [2:0] cfg_idx;
   logic [15:0] cfg_val;
   logic [15:0] prev_word_hint [SLOTS];

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] unit_component(longint c, longint len8);
      longint q;
      q = (c * (64'sd1 <<< 23)) / len8;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic logic [47:0] condition_stick(logic signed [15:0] x,
                                                   logic signed [15:0] y,
                                                   logic [14:0] dz);
      longint xs, ys, len8, lc8, d;
      longint unsigned s;
      logic [15:0] dx, dy, m;
      xs = x;
      ys = y;
      d = dz;
      s = xs * xs + ys * ys;
      if (s == 0 || s < d * d) return '0;
      len8 = root64(s << 16);
      dx = unit_component(xs, len8);
      dy = unit_component(ys, len8);
      if (d >= 32767) begin
         m = 16'd32768;
      end else begin
         lc8 = (len8 > 32767 * 256) ? 32767 * 256 : len8;
         m = 16'(((lc8 - d * 256) * 32768) / ((32767 - d) * 256));
      end
      return {dx, dy, m};
   endfunction

   task automatic predict_poll(poll_type p);
      logic [47:0] l, r;
      logic [15:0] now, prev;
      button_res_type e;
      int a;
      l = condition_stick(p.lx, p.ly, dz_model[p.slot]);
      r = condition_stick(p.rx, p.ry, dz_model[p.slot]);
      now = {2'b00, p.word[15:12], p.word[9:0]};
      if (p.lt > trig_model) now[14] = 1'b1;
      if (p.rt > trig_model) now[15] = 1'b1;
      prev = prev_mask[p.slot];
      for (int b = 0; b < BUTTONS; b++) begin
         a = p.slot * BUTTONS + b;
         if (!now[b]) hold_model[a] = 0;
         else if (!prev[b]) hold_model[a] = 1;
         else if (hold_model[a] != CNT_MAX) hold_model[a] = hold_model[a] + 1;
         e.slot = p.slot;
         e.idx = 4'(b);
         e.down = now[b];
         e.cnt = hold_model[a];
         e.last = (b == BUTTONS - 1);
         {e.ldx, e.ldy, e.lm} = l;
         {e.rdx, e.rdy, e.rm} = r;
         expected_buttons.push_back(e);
      end
      prev_mask[p.slot] = now;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_poll(req_item);
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 0;
         end else if (pending_polls.size() != 0) begin
            req_item <= pending_polls.pop_front();
            req_valid <= 1;
            req_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 2);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // register write driver
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_valid <= 0;
            cfg_done <= 1;
            if (csr_index < 4) dz_model[csr_index] = csr_wdata[14:0];
            else if (csr_index == CSR_TRIG) trig_model = csr_wdata[7:0];
         end else if (cfg_busy && !csr_valid && !cfg_done) begin
            csr_valid <= 1;
            csr_index <= cfg_idx;
            csr_wdata <= cfg_val;
         end
      end
   end

   // result monitor and ready pattern
   int ready_hold = 0;
   always @(posedge clock) begin
      button_res_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_buttons.size() == 0) begin
               $error("result with no expectation, button %0d", rsp_button_index);
               errors++;
            end else begin
               e = expected_buttons.pop_front();
               if (rsp_slot_echo !== e.slot) begin
                  $error("slot_echo exp %0d got %0d", e.slot, rsp_slot_echo); errors++;
               end
               if (rsp_button_index !== e.idx) begin
                  $error("button_index exp %0d got %0d", e.idx, rsp_button_index); errors++;
               end
               if (rsp_button_down !== e.down) begin
                  $error("button_down exp %0d got %0d", e.down, rsp_button_down); errors++;
               end
               if (rsp_hold_count !== e.cnt) begin
                  $error("hold_count exp %0d got %0d", e.cnt, rsp_hold_count); errors++;
               end
               if (rsp_last_of_run !== e.last) begin
                  $error("last_of_run exp %0d got %0d", e.last, rsp_last_of_run); errors++;
               end
               if (rsp_left_dir_x !== e.ldx) begin
                  $error("left_dir_x exp %0d got %0d", e.ldx, rsp_left_dir_x); errors++;
               end
               if (rsp_left_dir_y !== e.ldy) begin
                  $error("left_dir_y exp %0d got %0d", e.ldy, rsp_left_dir_y); errors++;
               end
               if (rsp_left_magnitude !== e.lm) begin
                  $error("left_magnitude exp %0d got %0d", e.lm, rsp_left_magnitude); errors++;
               end
               if (rsp_right_dir_x !== e.rdx) begin
                  $error("right_dir_x exp %0d got %0d", e.rdx, rsp_right_dir_x); errors++;
               end
               if (rsp_right_dir_y !== e.rdy) begin
                  $error("right_dir_y exp %0d got %0d", e.rdy, rsp_right_dir_y); errors++;
               end
               if (rsp_right_magnitude !== e.rm) begin
                  $error("right_magnitude exp %0d got %0d", e.rm, rsp_right_magnitude); errors++;
               end
            end
         end
         if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
         end else if (rsp_ready && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 3);
         end else begin
            rsp_ready <= 1;
            ready_hold <= $urandom_range(0, 1) ? $urandom_range(0, 30) : 0;
         end
      end
   end

   // watchdog: no transaction on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 5000) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 600)) - 300);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic poll_type rand_poll(logic [1:0] s);
      poll_type p;
      p.slot = s;
      p.lx = rand_axis();
      p.ly = rand_axis();
      p.rx = rand_axis();
      p.ry = rand_axis();
      p.word = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'(1 << $urandom_range(0, 15));
      if ($urandom_range(0, 1)) p.word = prev_word_hint[s];
      p.lt = 8'($urandom);
      p.rt = 8'($urandom);
      return p;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      cfg_idx = idx;
      cfg_val = val;
      cfg_done = 0;
      cfg_busy = 1;
      wait (cfg_done);
      @(posedge clock);
      cfg_busy = 0;
   endtask

   task automatic drain();
      wait (pending_polls.size() == 0 && !req_valid && expected_buttons.size() == 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic push(poll_type p);
      pending_polls.push_back(p);
      prev_word_hint[p.slot] = p.word;
   endtask

   initial begin
      poll_type p;
      for (int i = 0; i < SLOTS; i++) begin
         dz_model[i] = DZ_RESET;
         prev_mask[i] = 0;
         prev_word_hint[i] = 0;
      end
      trig_model = TRIG_RESET;
      for (int i = 0; i < CNT_DEPTH; i++) hold_model[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero, inside zone, extremes, all buttons, held and released
      p = '0;
      push(p);
      p.lx = 16'sd100; p.ly = -16'sd100; p.rx = 16'h8000; p.ry = 16'h8000;
      p.word = 16'hFFFF; p.lt = 8'hFF; p.rt = 8'd31;
      push(p);
      p.lx = 16'h7FFF; p.ly = 16'h0; p.rx = 16'h0; p.ry = 16'h8000; p.lt = 8'd30;
      push(p);
      p.word = 16'h0C00; p.lt = 0; p.rt = 0; p.lx = 16'd7864; p.ly = 0;
      push(p);
      for (int s = 1; s < SLOTS; s++) begin
         p.slot = 2'(s); p.word = 16'h5555 << s; p.lx = 16'h7FFF; p.ly = 16'h7FFF;
         push(p);
      end
      drain();

      write_reg(CSR_DZ0, 16'd0);
      write_reg(CSR_DZ1, 16'hFFFF);
      write_reg(CSR_DZ2, 16'd32766);
      write_reg(CSR_DZ3, 16'd1);
      write_reg(CSR_TRIG, 16'd0);
      write_reg(3'd7, 16'h1234);
      for (int s = 0; s < SLOTS; s++) begin
         p = '0; p.slot = 2'(s); p.lx = 16'h7FFF; p.ly = 16'h8000;
         p.rx = 16'sd1; p.lt = 8'd1; p.word = 16'hAAAA;
         push(p);
         p.lx = 16'h8000; p.ly = 16'h0; p.rx = 16'h7FFF; p.ry = 16'h0;
         push(p);
      end
      for (int i = 0; i < 60; i++) push(rand_poll(2'($urandom_range(0, 3))));
      drain();

      write_reg(CSR_TRIG, 16'd255);
      for (int s = 0; s < SLOTS; s++) write_reg(3'(s), 16'($urandom_range(0, 32767)));
      for (int i = 0; i < 60; i++) push(rand_poll(2'($urandom_range(0, 3))));
      drain();

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

[filelist.f]
rtl/gsdh_pkg.sv
rtl/gsdh_ram.sv
rtl/gsdh_div.sv
rtl/gsdh_stick.sv
rtl/gamepad_stick_deadzone_and_hold.sv
rtl/gsdh_checker.sv
tb/sv/tb.sv
